// ===== hdl/csmd_pkg.sv =====
// Package for the cosine similarity / max difference block.
// Widths, beat types and shared constants. No dependencies.
package csmd_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int VEC_ACC_BITS  = 44;
	localparam int RUN_ACC_BITS  = 50;
	localparam int COS_FRAC_BITS = 15;
	localparam int ROOT_BITS     = RUN_ACC_BITS / 2;
	localparam int MUL_BITS      = ROOT_BITS + 1;
	localparam int PROD_BITS     = 2 * MUL_BITS;

	localparam logic signed [15:0] COS_MAX     = 16'sd32767;
	localparam logic signed [15:0] COS_MAX_NEG = -16'sd32767;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] ref_sample;
		logic signed [SAMPLE_BITS-1:0] test_sample;
		logic                          last_of_vector;
		logic                          last_of_run;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] cosine;
		logic        [15:0] max_abs_diff;
		logic               is_overall;
		logic               last;
	} result_t;

endpackage

// ===== hdl/csmd_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on csmd_pkg.
module csmd_mul import csmd_pkg::*; (
	input  logic                        clk,
	input  logic signed [MUL_BITS-1:0]  op_a,
	input  logic signed [MUL_BITS-1:0]  op_b,
	output logic signed [PROD_BITS-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

// ===== hdl/csmd_root.sv =====
// Integer square root, one result bit per cycle (digit-by-digit).
// Depends on csmd_pkg.
module csmd_root import csmd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [RUN_ACC_BITS-1:0] radicand,
	output logic                    busy,
	output logic [ROOT_BITS-1:0]    root
);

	localparam int CNT_W = $clog2(ROOT_BITS + 1);
	localparam int REM_W = ROOT_BITS + 2;
	localparam int SH_W  = REM_W + 2;

	logic [RUN_ACC_BITS-1:0] rad_q;
	logic [REM_W-1:0]        rem_q;
	logic [ROOT_BITS-1:0]    root_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;

	logic [SH_W-1:0] rem_sh;
	logic [SH_W-1:0] trial;
	logic [SH_W-1:0] diff;

	always_comb begin
		rem_sh = {rem_q, rad_q[RUN_ACC_BITS-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ROOT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RUN_ACC_BITS-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= diff[REM_W-1:0];
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== hdl/csmd_div.sv =====
// Fractional restoring divider: quotient bits of num/den for num < den.
// One quotient bit per cycle. Depends on csmd_pkg.
module csmd_div import csmd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [RUN_ACC_BITS-1:0]  dividend,
	input  logic [RUN_ACC_BITS-1:0]  divisor,
	output logic                     busy,
	output logic [COS_FRAC_BITS-1:0] quotient
);

	localparam int CNT_W = $clog2(COS_FRAC_BITS + 1);

	logic [RUN_ACC_BITS-1:0]  rem_q;
	logic [RUN_ACC_BITS-1:0]  den_q;
	logic [COS_FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;

	logic [RUN_ACC_BITS:0] rem_sh;
	logic [RUN_ACC_BITS:0] diff;

	always_comb begin
		rem_sh = {rem_q, 1'b0};
		diff   = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(COS_FRAC_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= diff[RUN_ACC_BITS-1:0];
				quo_q <= {quo_q[COS_FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[RUN_ACC_BITS-1:0];
				quo_q <= {quo_q[COS_FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/cosine_similarity_max_diff.sv =====
// Cosine similarity with largest absolute difference, per vector and per run.
// Uses csmd_pkg, csmd_mul, csmd_root and csmd_div.
// Middle element: three products share one multiplier and are accumulated before the next beat is taken.
// End of vector: two 25-step roots, one product, then the 15-step divide when it runs; the
// overall result runs the same steps once the run's last vector result beat is taken.
// Reset clears the sequencer and all accumulators; ready rises in the first idle cycle.
module cosine_similarity_max_diff import csmd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_AB, S_ACC_AB, S_ACC_AA, S_ACC_BB,
		S_ROOT1_GO, S_ROOT1_WAIT, S_ROOT2_GO, S_ROOT2_WAIT,
		S_DEN_MUL, S_DEN_CHK, S_DIV_WAIT, S_OUT, S_TOTAL
	} state_t;

	state_t state_q;

	sample_t sample_q;
	logic signed [VEC_ACC_BITS-1:0] dot_q;
	logic        [VEC_ACC_BITS-1:0] ref_norm_q;
	logic        [VEC_ACC_BITS-1:0] test_norm_q;
	logic        [15:0]             max_diff_q;
	logic signed [RUN_ACC_BITS-1:0] tot_dot_q;
	logic        [RUN_ACC_BITS-1:0] tot_ref_q;
	logic        [RUN_ACC_BITS-1:0] tot_test_q;
	logic                           overall_q;
	logic        [ROOT_BITS-1:0]    r1_q;
	logic        [ROOT_BITS-1:0]    r2_q;
	result_t                        result_q;

	logic signed [MUL_BITS-1:0]  op_a, op_b;
	logic signed [PROD_BITS-1:0] prod_s1;
	logic                        root_start, root_busy;
	logic [ROOT_BITS-1:0]        root;
	logic                        div_start, div_busy;
	logic [COS_FRAC_BITS-1:0]    quotient;
	logic [RUN_ACC_BITS-1:0]     radicand;

	logic signed [MUL_BITS-1:0]     a_ext, b_ext;
	logic signed [VEC_ACC_BITS:0]   dot_sum;
	logic signed [VEC_ACC_BITS-1:0] dot_sat;
	logic        [VEC_ACC_BITS:0]   norm_sum;
	logic        [VEC_ACC_BITS-1:0] norm_sat;
	logic        [VEC_ACC_BITS-1:0] norm_base;
	logic signed [SAMPLE_BITS:0]    diff;
	logic        [SAMPLE_BITS:0]    abs_diff;
	logic        [15:0]             abs_sat;
	logic signed [RUN_ACC_BITS:0]   tdot_sum;
	logic signed [RUN_ACC_BITS-1:0] tdot_sat;
	logic        [RUN_ACC_BITS:0]   tref_sum, ttest_sum;
	logic        [RUN_ACC_BITS-1:0] tref_sat, ttest_sat;
	logic signed [RUN_ACC_BITS-1:0] src_dot;
	logic        [RUN_ACC_BITS-1:0] src_n1, src_n2;
	logic                           neg;
	logic        [RUN_ACC_BITS-1:0] mag;
	logic        [RUN_ACC_BITS-1:0] den;
	logic                           end_run;

	csmd_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	csmd_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.busy     (root_busy),
		.root     (root)
	);

	csmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (den),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		a_ext = {{(MUL_BITS-SAMPLE_BITS){sample_q.ref_sample[SAMPLE_BITS-1]}},
			sample_q.ref_sample};
		b_ext = {{(MUL_BITS-SAMPLE_BITS){sample_q.test_sample[SAMPLE_BITS-1]}},
			sample_q.test_sample};
		unique case (state_q)
			S_ACC_AB: begin
				op_a = a_ext;
				op_b = a_ext;
			end
			S_ACC_AA: begin
				op_a = b_ext;
				op_b = b_ext;
			end
			S_DEN_MUL: begin
				op_a = {1'b0, r1_q};
				op_b = {1'b0, r2_q};
			end
			default: begin
				op_a = a_ext;
				op_b = b_ext;
			end
		endcase
	end

	// saturating accumulation of the element products, and the saturated absolute difference
	always_comb begin
		dot_sum = {dot_q[VEC_ACC_BITS-1], dot_q} + prod_s1[VEC_ACC_BITS:0];
		if (dot_sum[VEC_ACC_BITS] != dot_sum[VEC_ACC_BITS-1]) begin
			dot_sat = {dot_sum[VEC_ACC_BITS], {(VEC_ACC_BITS-1){~dot_sum[VEC_ACC_BITS]}}};
		end else begin
			dot_sat = dot_sum[VEC_ACC_BITS-1:0];
		end
		norm_base = (state_q == S_ACC_AA) ? ref_norm_q : test_norm_q;
		norm_sum  = {1'b0, norm_base} + prod_s1[VEC_ACC_BITS:0];
		norm_sat  = norm_sum[VEC_ACC_BITS] ? '1 : norm_sum[VEC_ACC_BITS-1:0];

		diff     = {sample_q.ref_sample[SAMPLE_BITS-1], sample_q.ref_sample}
			- {sample_q.test_sample[SAMPLE_BITS-1], sample_q.test_sample};
		abs_diff = diff[SAMPLE_BITS] ? -diff : diff;
		abs_sat  = abs_diff[SAMPLE_BITS] ? 16'hFFFF : abs_diff[15:0];
	end

	// run totals
	always_comb begin
		tdot_sum = {tot_dot_q[RUN_ACC_BITS-1], tot_dot_q}
			+ {{(RUN_ACC_BITS-VEC_ACC_BITS+1){dot_q[VEC_ACC_BITS-1]}}, dot_q};
		if (tdot_sum[RUN_ACC_BITS] != tdot_sum[RUN_ACC_BITS-1]) begin
			tdot_sat = {tdot_sum[RUN_ACC_BITS], {(RUN_ACC_BITS-1){~tdot_sum[RUN_ACC_BITS]}}};
		end else begin
			tdot_sat = tdot_sum[RUN_ACC_BITS-1:0];
		end
		tref_sum  = {1'b0, tot_ref_q} + {(RUN_ACC_BITS-VEC_ACC_BITS+1)'(0), ref_norm_q};
		ttest_sum = {1'b0, tot_test_q} + {(RUN_ACC_BITS-VEC_ACC_BITS+1)'(0), test_norm_q};
		tref_sat  = tref_sum[RUN_ACC_BITS] ? '1 : tref_sum[RUN_ACC_BITS-1:0];
		ttest_sat = ttest_sum[RUN_ACC_BITS] ? '1 : ttest_sum[RUN_ACC_BITS-1:0];
	end

	// operands of the cosine, the root and divide starts, and the end of run
	always_comb begin
		if (overall_q) begin
			src_dot = tot_dot_q;
			src_n1  = tot_ref_q;
			src_n2  = tot_test_q;
		end else begin
			src_dot = {{(RUN_ACC_BITS-VEC_ACC_BITS){dot_q[VEC_ACC_BITS-1]}}, dot_q};
			src_n1  = {(RUN_ACC_BITS-VEC_ACC_BITS)'(0), ref_norm_q};
			src_n2  = {(RUN_ACC_BITS-VEC_ACC_BITS)'(0), test_norm_q};
		end
		neg        = src_dot[RUN_ACC_BITS-1];
		mag        = neg ? -src_dot : src_dot;
		den        = prod_s1[RUN_ACC_BITS-1:0];
		radicand   = (state_q == S_ROOT2_GO) ? src_n2 : src_n1;
		root_start = (state_q == S_ROOT1_GO) || (state_q == S_ROOT2_GO);
		div_start  = (state_q == S_DEN_CHK) && (den != '0) && (mag < den);
		end_run    = sample_q.last_of_vector && sample_q.last_of_run;
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			overall_q   <= 1'b0;
			dot_q       <= '0;
			ref_norm_q  <= '0;
			test_norm_q <= '0;
			max_diff_q  <= '0;
			tot_dot_q   <= '0;
			tot_ref_q   <= '0;
			tot_test_q  <= '0;
			r1_q        <= '0;
			r2_q        <= '0;
			result_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_MUL_AB;
					end
				end
				S_MUL_AB: begin
					if (abs_sat > max_diff_q) begin
						max_diff_q <= abs_sat;
					end
					state_q <= S_ACC_AB;
				end
				S_ACC_AB: begin
					dot_q   <= dot_sat;
					state_q <= S_ACC_AA;
				end
				S_ACC_AA: begin
					ref_norm_q <= norm_sat;
					state_q    <= S_ACC_BB;
				end
				S_ACC_BB: begin
					test_norm_q <= norm_sat;
					overall_q   <= 1'b0;
					state_q     <= sample_q.last_of_vector ? S_ROOT1_GO : S_IDLE;
				end
				S_ROOT1_GO: begin
					state_q <= S_ROOT1_WAIT;
				end
				S_ROOT1_WAIT: begin
					if (!root_busy) begin
						r1_q    <= root;
						state_q <= S_ROOT2_GO;
					end
				end
				S_ROOT2_GO: begin
					state_q <= S_ROOT2_WAIT;
				end
				S_ROOT2_WAIT: begin
					if (!root_busy) begin
						r2_q    <= root;
						state_q <= S_DEN_MUL;
					end
				end
				S_DEN_MUL: begin
					state_q <= S_DEN_CHK;
				end
				S_DEN_CHK: begin
					result_q.max_abs_diff <= overall_q ? 16'd0 : max_diff_q;
					result_q.is_overall   <= overall_q;
					result_q.last         <= overall_q || !end_run;
					priority if (den == '0) begin
						result_q.cosine <= '0;
						state_q         <= S_OUT;
					end else if (mag >= den) begin
						result_q.cosine <= neg ? COS_MAX_NEG : COS_MAX;
						state_q         <= S_OUT;
					end else begin
						state_q <= S_DIV_WAIT;
					end
				end
				S_DIV_WAIT: begin
					if (!div_busy) begin
						result_q.cosine <= neg ? -$signed({1'b0, quotient})
							: $signed({1'b0, quotient});
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (result_ready) begin
						if (overall_q) begin
							tot_dot_q  <= '0;
							tot_ref_q  <= '0;
							tot_test_q <= '0;
							overall_q  <= 1'b0;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_TOTAL;
						end
					end
				end
				S_TOTAL: begin
					tot_dot_q   <= tdot_sat;
					tot_ref_q   <= tref_sat;
					tot_test_q  <= ttest_sat;
					dot_q       <= '0;
					ref_norm_q  <= '0;
					test_norm_q <= '0;
					max_diff_q  <= '0;
					if (end_run) begin
						overall_q <= 1'b1;
						state_q   <= S_ROOT1_GO;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sample_ready = (state_q == S_IDLE);
	assign result_valid = (state_q == S_OUT);
	assign result       = result_q;

endmodule

// ===== hdl/csmd_checker.sv =====
// Port-level checks for cosine_similarity_max_diff, and the bind that attaches them.
// Depends on csmd_pkg.
module csmd_checker import csmd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_valid,
	input logic    sample_ready,
	input sample_t sample,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("ready stayed high after an input beat");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_ready && result_valid))
		else $error("input taken while a result is pending");

	a_overall_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_overall |-> result.last && (result.max_abs_diff == 16'd0))
		else $error("overall result has bad last or max_abs_diff");

	a_cosine_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.cosine != 16'sh8000)
		else $error("cosine outside +/-32767");

endmodule

bind cosine_similarity_max_diff csmd_checker u_csmd_checker (.*);
